@@ hw/rtl/esb_pkg.sv @@
// Shared widths, request codes, register indexes and controller commands
// for the edge-spread supersample binner. No dependencies.
`timescale 1ns / 1ps

package esb_pkg;

  localparam int unsigned SLOPE_W   = 19;
  localparam int unsigned ROWS_W    = 11;
  localparam int unsigned COLS_W    = 9;
  localparam int unsigned COL_W     = 8;
  localparam int unsigned ROW_W     = 10;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned BIDX_W    = 10;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned CNT_W     = 19;
  localparam int unsigned SUM_W     = 18;
  localparam int unsigned MEAN_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DVD_W     = SUM_W + 9;

  localparam int unsigned COL_LSB  = 0;
  localparam int unsigned ROW_LSB  = COL_LSB + COL_W;
  localparam int unsigned PIX_LSB  = ROW_LSB + ROW_W;
  localparam int unsigned BIDX_LSB = PIX_LSB + PIX_W;
  localparam int unsigned IN_W     = ((BIDX_LSB + BIDX_W + 7) / 8) * 8;

  localparam int unsigned FACTOR_DEF = 4;
  localparam int unsigned BINS_DEF   = 2048;

  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FIN   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd2;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_CLR_WR,
    CMD_LATCH,
    CMD_MUL,
    CMD_OFS,
    CMD_BIN,
    CMD_ADD_RD,
    CMD_ADD_WR,
    CMD_FL_LRD,
    CMD_FL_LCAP,
    CMD_FL_RD,
    CMD_FL_WR,
    CMD_RD_RD,
    CMD_RD_CHK,
    CMD_OUT_LOAD
  } cmd_e;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             clr_last;
    logic             fill_done;
    logic             rd_ok;
    logic             cnt_zero;
    logic             div_done;
    logic             out_busy;
  } status_t;

endpackage

@@ hw/rtl/esb_div.sv @@
// Restoring divider, one quotient bit per cycle, for the bin mean.
// Depends on esb_pkg for the dividend and divisor widths.
`timescale 1ns / 1ps

module esb_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [esb_pkg::DVD_W-1:0] dividend_i,
  input  logic [esb_pkg::CNT_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [esb_pkg::DVD_W-1:0] quot_o
);
  import esb_pkg::*;

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] rem_q;
  logic [DVD_W-1:0] quo_q;
  logic [CNT_W-1:0] dvs_q;
  logic [CW-1:0]    cnt_q;
  logic             done_q;
  logic [CNT_W:0]   shifted;
  logic [CNT_W+1:0] trial;

  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(DVD_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      if (!trial[CNT_W+1]) begin
        rem_q <= trial[CNT_W-1:0];
        quo_q <= {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[CNT_W-1:0];
        quo_q <= {quo_q[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ hw/rtl/esb_dp.sv @@
// Datapath of the binner: configuration registers, projection arithmetic,
// count and sum memories, fill walk and mean output register.
// Depends on esb_pkg and esb_div.
`timescale 1ns / 1ps

module esb_dp #(
  parameter int unsigned FACTOR = esb_pkg::FACTOR_DEF,
  parameter int unsigned BINS   = esb_pkg::BINS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  esb_pkg::cmd_e                 cmd_i,
  output esb_pkg::status_t              status_o,
  input  logic                          cfg_we_i,
  input  logic [esb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [esb_pkg::SLOPE_W-1:0]   cfg_data_i,
  input  logic [esb_pkg::IN_W-1:0]      in_data_i,
  input  logic [esb_pkg::REQ_W-1:0]     in_user_i,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [esb_pkg::MEAN_W-1:0]    m_axis_tdata,
  output logic                          m_axis_tuser
);
  import esb_pkg::*;

  localparam int unsigned AW   = $clog2(BINS);
  localparam int unsigned FW   = $clog2(FACTOR + 1);
  localparam int unsigned P_W  = ROWS_W + 1 + SLOPE_W;
  localparam int unsigned RS_W = ROW_W + 1 + SLOPE_W;
  localparam int unsigned XW   = P_W + FW + 1;

  localparam logic signed [XW-1:0] FACT_S = XW'(FACTOR);
  localparam logic signed [XW-1:0] BINS_S = XW'(BINS);
  localparam logic signed [XW-1:0] HALF_S = XW'(32768);
  localparam logic signed [XW-1:0] CEIL_S = XW'(65535);
  localparam logic signed [XW-1:0] ONE_S  = XW'(1);
  localparam logic [CNT_W-1:0]     CNT_MAX = '1;
  localparam logic [SUM_W-1:0]     SUM_MAX = '1;
  localparam logic [DVD_W-1:0]     MEAN_MAX = DVD_W'(65535);

  logic signed [SLOPE_W-1:0] slope_q;
  logic [ROWS_W-1:0]         rows_q;
  logic [COLS_W-1:0]         cols_q;

  logic [REQ_W-1:0]  req_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [PIX_W-1:0]  pix_q;
  logic [BIDX_W-1:0] bidx_q;

  logic signed [P_W-1:0]  p_q;
  logic signed [RS_W-1:0] rs_q;
  logic signed [XW-1:0]   r_q;
  logic signed [XW-1:0]   c_q;
  logic [AW-1:0]          bin_q;
  logic                   add_ok_q;
  logic [AW-1:0]          idx_q;
  logic                   rd_ok_q;
  logic signed [XW-1:0]   i_q;
  logic signed [XW-1:0]   end_q;
  logic [CNT_W-1:0]       left_q;
  logic [AW-1:0]          clr_q;
  logic                   empty_q;

  logic [CNT_W-1:0] cnt_mem [BINS];
  logic [SUM_W-1:0] sum_mem [BINS];
  logic [CNT_W-1:0] rcnt_q;
  logic [SUM_W-1:0] rsum_q;
  logic [CNT_W-1:0] rcntb_q;

  logic                  m_valid_q;
  logic [MEAN_W-1:0]     m_mean_q;
  logic                  m_empty_q;

  logic [ROWS_W-1:0]     rm1;
  logic signed [P_W-1:0] p_d;
  logic signed [RS_W-1:0] rs_d;
  logic signed [XW-1:0]  pext;
  logic signed [XW-1:0]  nval;
  logic signed [XW-1:0]  r_d;
  logic signed [XW-1:0]  aval;
  logic signed [XW-1:0]  c_d;
  logic signed [XW-1:0]  offv;
  logic signed [XW-1:0]  binx;
  logic signed [XW-1:0]  absr;
  logic signed [XW-1:0]  first;
  logic signed [XW-1:0]  idxx;

  logic [AW-1:0]    ra;
  logic [AW-1:0]    rb;
  logic             we;
  logic [AW-1:0]    wa;
  logic [CNT_W-1:0] wcnt;
  logic [SUM_W-1:0] wsum;
  logic [SUM_W:0]   sum_inc;
  logic             rb_ok;
  logic [CNT_W-1:0] right;
  logic [CNT_W+1:0] avg_sum;
  logic [CNT_W-1:0] fill_new;

  logic             div_start;
  logic [DVD_W-1:0] dividend;
  logic             div_busy;
  logic             div_done;
  logic [DVD_W-1:0] quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q <= '0;
      rows_q  <= ROWS_W'(1);
      cols_q  <= COLS_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLOPE: slope_q <= cfg_data_i;
        CFG_ROWS:  rows_q  <= cfg_data_i[ROWS_W-1:0];
        CFG_COLS:  cols_q  <= cfg_data_i[COLS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rm1  = (rows_q == '0) ? '0 : rows_q - 1'b1;
    p_d  = $signed({1'b0, rm1}) * slope_q;
    rs_d = $signed({1'b0, row_q}) * slope_q;
    pext = {{(XW-P_W){p_q[P_W-1]}}, p_q};
    nval = -(FACT_S * pext);
    if (nval >= 0) begin
      r_d = (nval + HALF_S) >>> 16;
    end else begin
      r_d = -((-nval + HALF_S) >>> 16);
    end
    aval = FACT_S * ($signed({{(XW-COL_W-16){1'b0}}, col_q, 16'h0000})
                     - {{(XW-RS_W){rs_q[RS_W-1]}}, rs_q});
    c_d  = (aval + CEIL_S) >>> 16;
    offv  = (r_q < 0) ? r_q : '0;
    binx  = c_q - offv;
    absr  = (r_q < 0) ? -r_q : r_q;
    first = (absr + ONE_S) >>> 1;
    idxx  = first + $signed({{(XW-BIDX_W){1'b0}}, bidx_q});
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LATCH: begin
        req_q  <= in_user_i;
        col_q  <= in_data_i[COL_LSB +: COL_W];
        row_q  <= in_data_i[ROW_LSB +: ROW_W];
        pix_q  <= in_data_i[PIX_LSB +: PIX_W];
        bidx_q <= in_data_i[BIDX_LSB +: BIDX_W];
      end
      CMD_MUL: begin
        p_q  <= p_d;
        rs_q <= rs_d;
      end
      CMD_OFS: begin
        r_q <= r_d;
        c_q <= c_d;
      end
      CMD_BIN: begin
        bin_q    <= binx[AW-1:0];
        add_ok_q <= (binx >= 0) && (binx < BINS_S);
        idx_q    <= idxx[AW-1:0];
        rd_ok_q  <= (idxx < BINS_S);
        i_q      <= first;
        end_q    <= first + FACT_S * $signed({{(XW-COLS_W){1'b0}}, cols_q});
      end
      CMD_FL_LCAP: begin
        left_q <= rcnt_q;
      end
      CMD_FL_WR: begin
        left_q <= (rcnt_q == '0) ? fill_new : rcnt_q;
        i_q    <= i_q + ONE_S;
      end
      CMD_RD_CHK: begin
        empty_q <= !(rd_ok_q && (rcnt_q != '0));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i == CMD_CLR_WR) begin
      clr_q <= (clr_q == AW'(BINS - 1)) ? '0 : clr_q + 1'b1;
    end
  end

  always_comb begin
    case (cmd_i)
      CMD_ADD_RD: ra = bin_q;
      CMD_FL_LRD: ra = i_q[AW-1:0] - 1'b1;
      CMD_FL_RD:  ra = i_q[AW-1:0];
      CMD_RD_RD:  ra = idx_q;
      default:    ra = bin_q;
    endcase
    rb = i_q[AW-1:0] + 1'b1;

    rb_ok    = (i_q + ONE_S) < BINS_S;
    right    = rb_ok ? rcntb_q : '0;
    avg_sum  = {2'b00, left_q} + {2'b00, right} + (CNT_W+2)'(1);
    fill_new = (i_q == 0) ? right : avg_sum[CNT_W:1];
    sum_inc  = {1'b0, rsum_q} + (SUM_W+1)'(pix_q);

    we   = 1'b0;
    wa   = clr_q;
    wcnt = '0;
    wsum = '0;
    case (cmd_i)
      CMD_CLR_WR: begin
        we = 1'b1;
      end
      CMD_ADD_WR: begin
        we   = add_ok_q;
        wa   = bin_q;
        wcnt = (rcnt_q == CNT_MAX) ? rcnt_q : rcnt_q + 1'b1;
        wsum = sum_inc[SUM_W] ? SUM_MAX : sum_inc[SUM_W-1:0];
      end
      CMD_FL_WR: begin
        we   = (rcnt_q == '0);
        wa   = i_q[AW-1:0];
        wcnt = fill_new;
        wsum = rsum_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      cnt_mem[wa] <= wcnt;
      sum_mem[wa] <= wsum;
    end
  end

  always_ff @(posedge clk_i) begin
    rcnt_q  <= cnt_mem[ra];
    rsum_q  <= sum_mem[ra];
    rcntb_q <= cnt_mem[rb];
  end

  assign div_start = (cmd_i == CMD_RD_CHK) && rd_ok_q && (rcnt_q != '0);
  assign dividend  = {1'b0, rsum_q, 8'h00} + DVD_W'(rcnt_q >> 1);

  esb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (rcnt_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i == CMD_OUT_LOAD) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_OUT_LOAD) begin
      m_empty_q <= empty_q;
      if (empty_q) begin
        m_mean_q <= '0;
      end else if (quot > MEAN_MAX) begin
        m_mean_q <= '1;
      end else begin
        m_mean_q <= quot[MEAN_W-1:0];
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_mean_q;
  assign m_axis_tuser  = m_empty_q;

  always_comb begin
    status_o.req       = req_q;
    status_o.clr_last  = (clr_q == AW'(BINS - 1));
    status_o.fill_done = (i_q >= end_q) || (i_q >= BINS_S);
    status_o.rd_ok     = rd_ok_q;
    status_o.cnt_zero  = (rcnt_q == '0);
    status_o.div_done  = div_done;
    status_o.out_busy  = m_valid_q && !m_axis_tready;
  end

`ifndef ASSERT_OFF
  a_empty_mean_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("empty bin delivered with a nonzero mean");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_clr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i != CMD_CLR_WR) |=> $stable(clr_q))
    else $error("clear pointer moved outside a clear pass");
`endif

endmodule

@@ hw/rtl/esb_ctrl.sv @@
// Controller state machine of the binner: sequences the clear pass, the
// projection steps and the add, fill and read operations. Depends on esb_pkg.
`timescale 1ns / 1ps

module esb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  esb_pkg::status_t status_i,
  output esb_pkg::cmd_e    cmd_o
);
  import esb_pkg::*;

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_MUL     = 4'd2;
  localparam logic [3:0] S_OFS     = 4'd3;
  localparam logic [3:0] S_BIN     = 4'd4;
  localparam logic [3:0] S_ADD_RD  = 4'd5;
  localparam logic [3:0] S_ADD_WR  = 4'd6;
  localparam logic [3:0] S_FL_LRD  = 4'd7;
  localparam logic [3:0] S_FL_LCAP = 4'd8;
  localparam logic [3:0] S_FL_RD   = 4'd9;
  localparam logic [3:0] S_FL_WR   = 4'd10;
  localparam logic [3:0] S_RD_RD   = 4'd11;
  localparam logic [3:0] S_RD_CHK  = 4'd12;
  localparam logic [3:0] S_RD_WAIT = 4'd13;
  localparam logic [3:0] S_RD_OUT  = 4'd14;

  logic [3:0] state_q;
  logic [3:0] state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = CMD_NOP;
    s_axis_tready = 1'b0;
    case (state_q)
      S_CLR: begin
        cmd_o = CMD_CLR_WR;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o   = CMD_LATCH;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o   = CMD_MUL;
        state_d = S_OFS;
      end
      S_OFS: begin
        cmd_o   = CMD_OFS;
        state_d = S_BIN;
      end
      S_BIN: begin
        cmd_o = CMD_BIN;
        case (status_i.req)
          REQ_ADD:   state_d = S_ADD_RD;
          REQ_FIN:   state_d = S_FL_LRD;
          REQ_READ:  state_d = S_RD_RD;
          REQ_CLEAR: state_d = S_CLR;
          default:   state_d = S_IDLE;
        endcase
      end
      S_ADD_RD: begin
        cmd_o   = CMD_ADD_RD;
        state_d = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd_o   = CMD_ADD_WR;
        state_d = S_IDLE;
      end
      S_FL_LRD: begin
        cmd_o   = CMD_FL_LRD;
        state_d = S_FL_LCAP;
      end
      S_FL_LCAP: begin
        cmd_o   = CMD_FL_LCAP;
        state_d = S_FL_RD;
      end
      S_FL_RD: begin
        if (status_i.fill_done) begin
          state_d = S_IDLE;
        end else begin
          cmd_o   = CMD_FL_RD;
          state_d = S_FL_WR;
        end
      end
      S_FL_WR: begin
        cmd_o   = CMD_FL_WR;
        state_d = S_FL_RD;
      end
      S_RD_RD: begin
        cmd_o   = CMD_RD_RD;
        state_d = S_RD_CHK;
      end
      S_RD_CHK: begin
        cmd_o = CMD_RD_CHK;
        if (status_i.rd_ok && !status_i.cnt_zero) begin
          state_d = S_RD_WAIT;
        end else begin
          state_d = S_RD_OUT;
        end
      end
      S_RD_WAIT: begin
        if (status_i.div_done) begin
          state_d = S_RD_OUT;
        end
      end
      S_RD_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o   = CMD_OUT_LOAD;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/edge_spread_supersample_binner_unit.sv @@
// Slanted-edge projection binner with supersampled count and sum bins.
// The input stream carries one request per transfer, the configuration
// port sets slope, rows and columns, and the output stream carries means.
// Transfers happen when tvalid and tready are both high.
// Requests in tuser: add pixel, finish (fill empty bins), read bin, clear.
// Only a read produces an output transfer: the Q8.8 mean and an empty flag.
// The controller handles one request at a time; tready is high while it idles.
// An add runs through the projection multiply and the memory
// read-modify-write. A read waits on the bit-serial divider (27 steps).
// A finish reads each window bin and writes only the empty ones, and a
// clear writes zero to every bin.
// After reset the block sweeps the memories to zero and takes no request
// meanwhile; configuration writes are taken at any time.
// A read result waits in the output register while the receiver stalls,
// and later requests are accepted until another read result must be loaded.
`timescale 1ns / 1ps

module edge_spread_supersample_binner_unit #(
  parameter int unsigned FACTOR = esb_pkg::FACTOR_DEF,
  parameter int unsigned BINS   = esb_pkg::BINS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [esb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [esb_pkg::SLOPE_W-1:0]   cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // col [7:0], row [17:8], pixel [25:18], bin_index [35:26], zero [39:36]
  input  logic [esb_pkg::IN_W-1:0]      s_axis_tdata,
  // req_type [1:0]
  input  logic [esb_pkg::REQ_W-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // bin_mean [15:0]
  output logic [esb_pkg::MEAN_W-1:0]    m_axis_tdata,
  // bin_empty [0]
  output logic                          m_axis_tuser
);
  import esb_pkg::*;

  cmd_e    cmd;
  status_t status;

  esb_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  esb_dp #(
    .FACTOR (FACTOR),
    .BINS   (BINS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_data_i     (s_axis_tdata),
    .in_user_i     (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
